// ===== hw/rtl/qpht_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qpht_pkg: shared definitions for the quadratic probe hash table
// Sizes, operation, status and slot mark codes, and controller/datapath types.
// ----------------------------------------------------------------------------
package qpht_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int VALUE_WIDTH = 32;
   localparam int SEQ_WIDTH   = 16;
   localparam int IP_WIDTH    = 32;
   localparam int CSR_W       = 11;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int SIZE_W      = IDX_W + 1;
   localparam int KEY_W       = IP_WIDTH + SEQ_WIDTH;
   localparam int HBYTE_W     = IDX_W + 6;
   localparam int ACC_W       = (SEQ_WIDTH > HBYTE_W) ? SEQ_WIDTH : HBYTE_W;
   localparam int CNT_W       = $clog2(ACC_W + 1);
   localparam int CSR_RESET   = 1021;

   typedef logic [1:0] op_type;
   localparam op_type OP_FIND   = 2'd0;
   localparam op_type OP_INSERT = 2'd1;
   localparam op_type OP_REMOVE = 2'd2;

   typedef logic [1:0] status_type;
   localparam status_type STAT_DONE = 2'd0;
   localparam status_type STAT_MISS = 2'd1;
   localparam status_type STAT_FULL = 2'd2;

   typedef logic [1:0] mark_type;
   localparam mark_type MARK_EMPTY   = 2'd0;
   localparam mark_type MARK_VALID   = 2'd1;
   localparam mark_type MARK_DELETED = 2'd2;

   typedef struct packed {
      logic             clear;
      logic [IDX_W-1:0] clear_addr;
      logic             accept;
      logic             shift;
      logic             load_byte;
      logic [1:0]       byte_idx;
      logic             probe_start;
      logic             probe_next;
      logic             finish;
      logic             stopped;
   } cmd_type;

   typedef struct packed {
      logic pass;
      logic k_last;
      logic rsp_busy;
   } sts_type;

endpackage
`default_nettype wire

// ===== hw/rtl/qpht_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qpht_if: request and response channels
// Valid/ready channels carrying table operations and their results.
// ----------------------------------------------------------------------------
interface qpht_req_if;
   logic                            valid;
   logic                            ready;
   qpht_pkg::op_type                op;
   logic [qpht_pkg::IP_WIDTH-1:0]    ip_addr;
   logic [qpht_pkg::SEQ_WIDTH-1:0]   seq;
   logic [qpht_pkg::VALUE_WIDTH-1:0] value_in;
   modport source (output valid, op, ip_addr, seq, value_in, input ready);
   modport sink   (input valid, op, ip_addr, seq, value_in, output ready);
endinterface

interface qpht_rsp_if;
   logic                            valid;
   logic                            ready;
   qpht_pkg::status_type            status;
   logic [qpht_pkg::VALUE_WIDTH-1:0] value_out;
   logic [qpht_pkg::IDX_W-1:0]       slot;
   modport source (output valid, status, value_out, slot, input ready);
   modport sink   (input valid, status, value_out, slot, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/quadratic_probe_hash_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table: open-addressing table with quadratic probing
// Find, insert and remove on keys of address plus sequence number.
//
//   channel   dir   handshake        payload
//   req_if    in    valid/ready      op, ip_addr, seq, value_in
//   rsp_if    out   valid/ready      status, value_out, slot
//   csr_      in    write enable     table_size
//
// One operation at a time: an accept step, serial hashing rounds in the bit-serial
// modulo reducer, a memory read and a check for each slot probed, and a final step
// to post the result.
// After reset a clearing sweep marks every slot empty;
// requests are held off until it ends.
// A stalled response holds only the final hand-off, the next request is taken meanwhile.
// ----------------------------------------------------------------------------
module quadratic_probe_hash_table (
   input  wire logic                       clock,
   input  wire logic                       reset,
   qpht_req_if.sink                        req_if,
   qpht_rsp_if.source                      rsp_if,
   input  wire logic                       csr_we,
   input  wire logic [qpht_pkg::CSR_W-1:0] csr_wdata
);

   qpht_pkg::cmd_type cmd;
   qpht_pkg::sts_type sts;

   qpht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   qpht_dpath u_dpath (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .req_op        (req_if.op),
      .req_ip_addr   (req_if.ip_addr),
      .req_seq       (req_if.seq),
      .req_value_in  (req_if.value_in),
      .rsp_ready     (rsp_if.ready),
      .rsp_valid     (rsp_if.valid),
      .rsp_status    (rsp_if.status),
      .rsp_value_out (rsp_if.value_out),
      .rsp_slot      (rsp_if.slot),
      .cmd           (cmd),
      .sts           (sts)
   );

endmodule
`default_nettype wire

// ===== hw/rtl/qpht_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qpht_ctrl: operation sequencer
// Clearing sweep, serial hash reduction rounds, probe loop and result hand-off.
// ----------------------------------------------------------------------------
module qpht_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_ready,
   input  wire qpht_pkg::sts_type sts,
   output      qpht_pkg::cmd_type cmd
);

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_HASH  = 7'b0000100,
      S_LOAD  = 7'b0001000,
      S_RD    = 7'b0010000,
      S_CHK   = 7'b0100000,
      S_FIN   = 7'b1000000
   } state_type;

   state_type                      state_ff, state_in;
   logic [qpht_pkg::IDX_W-1:0]     clr_ff, clr_in;
   logic [qpht_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [2:0]                     round_ff, round_in;
   logic                           stopped_ff, stopped_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_ff     <= '0;
         cnt_ff     <= '0;
         round_ff   <= '0;
         stopped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         cnt_ff     <= cnt_in;
         round_ff   <= round_in;
         stopped_ff <= stopped_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      cnt_in     = cnt_ff;
      round_in   = round_ff;
      stopped_in = stopped_ff;
      cmd        = '0;
      cmd.clear_addr = clr_ff;
      cmd.stopped    = stopped_ff;
      cmd.byte_idx   = 2'(3'd4 - round_ff);
      case (state_ff)
         S_CLEAR: begin
            cmd.clear = 1'b1;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == qpht_pkg::IDX_W'(qpht_pkg::TABLE_DEPTH - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               cnt_in     = '0;
               round_in   = '0;
               state_in   = S_HASH;
            end
         end
         S_HASH: begin
            cmd.shift = 1'b1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == qpht_pkg::CNT_W'(qpht_pkg::ACC_W - 1)) begin
               cnt_in   = '0;
               round_in = round_ff + 1'b1;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            if (round_ff == 3'd5) begin
               cmd.probe_start = 1'b1;
               state_in        = S_RD;
            end else begin
               cmd.load_byte = 1'b1;
               state_in      = S_HASH;
            end
         end
         S_RD: begin
            state_in = S_CHK;
         end
         S_CHK: begin
            if (!sts.pass) begin
               stopped_in = 1'b1;
               state_in   = S_FIN;
            end else if (sts.k_last) begin
               stopped_in = 1'b0;
               state_in   = S_FIN;
            end else begin
               cmd.probe_next = 1'b1;
               state_in       = S_RD;
            end
         end
         S_FIN: begin
            if (!sts.rsp_busy) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !sts.rsp_busy)
      else $error("result loaded while output still held");
   a_accept_hash: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_HASH))
      else $error("accepted transfer did not start hashing");
   a_clear_block: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_ready)
      else $error("request taken during clearing sweep");
   a_probe_after_hash: assert property (@(posedge clock) disable iff (reset)
      cmd.probe_start |-> (round_ff == 3'd5))
      else $error("probe started before hash complete");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/qpht_dpath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qpht_dpath: hash table datapath
// Size register, serial modulo reducer, probe address walk, slot memories
// and the response register.
// ----------------------------------------------------------------------------
module qpht_dpath (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [qpht_pkg::CSR_W-1:0]         csr_wdata,
   input  wire qpht_pkg::op_type                   req_op,
   input  wire logic [qpht_pkg::IP_WIDTH-1:0]      req_ip_addr,
   input  wire logic [qpht_pkg::SEQ_WIDTH-1:0]     req_seq,
   input  wire logic [qpht_pkg::VALUE_WIDTH-1:0]   req_value_in,
   input  wire logic                               rsp_ready,
   output      logic                               rsp_valid,
   output      qpht_pkg::status_type               rsp_status,
   output      logic [qpht_pkg::VALUE_WIDTH-1:0]   rsp_value_out,
   output      logic [qpht_pkg::IDX_W-1:0]         rsp_slot,
   input  wire qpht_pkg::cmd_type                  cmd,
   output      qpht_pkg::sts_type                  sts
);

   localparam int IW = qpht_pkg::IDX_W;
   localparam int SW = qpht_pkg::SIZE_W;
   localparam int AW = qpht_pkg::ACC_W;

   logic [qpht_pkg::CSR_W-1:0]       csr_ff;
   logic [SW-1:0]                    t_ff;
   logic [SW-1:0]                    t_eff;
   qpht_pkg::op_type                 op_ff;
   logic [qpht_pkg::IP_WIDTH-1:0]    ip_ff;
   logic [qpht_pkg::KEY_W-1:0]       key_ff;
   logic [qpht_pkg::VALUE_WIDTH-1:0] val_ff;
   logic [AW-1:0]                    acc_ff, acc_in;
   logic [IW-1:0]                    r_ff, r_in;
   logic [IW-1:0]                    home_ff, pos_ff, sq_ff, d_ff;
   logic [SW-1:0]                    k_ff;
   logic [IW-1:0]                    pos_in, sq_in, d_in;
   logic [SW-1:0]                    r2, s_sum, d_sum, p_sum, p_sub;
   logic [7:0]                       byte_sel;
   logic [31:0]                      csr_ext;

   qpht_pkg::mark_type               mark_mem [qpht_pkg::TABLE_DEPTH];
   logic [qpht_pkg::KEY_W-1:0]       key_mem  [qpht_pkg::TABLE_DEPTH];
   logic [qpht_pkg::VALUE_WIDTH-1:0] val_mem  [qpht_pkg::TABLE_DEPTH];
   qpht_pkg::mark_type               mark_rd_ff;
   logic [qpht_pkg::KEY_W-1:0]       key_rd_ff;
   logic [qpht_pkg::VALUE_WIDTH-1:0] val_rd_ff;

   logic                             rsp_valid_ff;
   qpht_pkg::status_type             status_ff;
   logic [qpht_pkg::VALUE_WIDTH-1:0] vout_ff;
   logic [IW-1:0]                    slot_ff;
   qpht_pkg::status_type             status_in;
   logic [qpht_pkg::VALUE_WIDTH-1:0] vout_in;
   logic                             hit;

   // effective table size
   always_comb begin
      csr_ext = 32'(csr_ff);
      if (csr_ext < 32'd2) t_eff = SW'(2);
      else if (csr_ext > 32'(qpht_pkg::TABLE_DEPTH)) t_eff = SW'(qpht_pkg::TABLE_DEPTH);
      else t_eff = SW'(csr_ext);
   end

   always_ff @(posedge clock) begin
      if (reset) csr_ff <= qpht_pkg::CSR_W'(qpht_pkg::CSR_RESET);
      else if (csr_we) csr_ff <= csr_wdata;
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         t_ff   <= t_eff;
         op_ff  <= req_op;
         ip_ff  <= req_ip_addr;
         key_ff <= {req_ip_addr, req_seq};
         val_ff <= req_value_in;
      end
   end

   // serial remainder: one bit of the accumulator per cycle while shifting
   always_comb begin
      byte_sel = ip_ff[8*cmd.byte_idx +: 8];
      r2       = {r_ff, acc_ff[AW-1]};
      if (r2 >= t_ff) r2 = r2 - t_ff;
      acc_in = acc_ff;
      r_in   = r_ff;
      if (cmd.accept) begin
         acc_in = AW'(req_seq);
         r_in   = '0;
      end else if (cmd.load_byte) begin
         acc_in = AW'(AW'(r_ff) * AW'(31)) + AW'(byte_sel);
         r_in   = '0;
      end else if (cmd.shift) begin
         acc_in = {acc_ff[AW-2:0], 1'b0};
         r_in   = r2[IW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      r_ff   <= r_in;
   end

   // quadratic probe walk: sq tracks q*q, d tracks 2q+1, both mod t
   always_comb begin
      s_sum = SW'(sq_ff) + SW'(d_ff);
      if (s_sum >= t_ff) s_sum = s_sum - t_ff;
      d_sum = SW'(d_ff) + SW'(2);
      if (d_sum >= t_ff) d_sum = d_sum - t_ff;
      sq_in = sq_ff;
      d_in  = d_ff;
      if (!k_ff[0]) begin
         sq_in = s_sum[IW-1:0];
         d_in  = d_sum[IW-1:0];
      end
      p_sum = SW'(home_ff) + SW'(sq_in);
      if (p_sum >= t_ff) p_sum = p_sum - t_ff;
      if (home_ff >= sq_in) p_sub = SW'(home_ff) - SW'(sq_in);
      else p_sub = SW'(home_ff) + t_ff - SW'(sq_in);
      pos_in = (!k_ff[0]) ? p_sum[IW-1:0] : p_sub[IW-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.probe_start) begin
         home_ff <= r_ff;
         pos_ff  <= r_ff;
         k_ff    <= '0;
         sq_ff   <= '0;
         d_ff    <= IW'(1);
      end else if (cmd.probe_next) begin
         pos_ff <= pos_in;
         k_ff   <= k_ff + 1'b1;
         sq_ff  <= sq_in;
         d_ff   <= d_in;
      end
   end

   // slot stores
   always_ff @(posedge clock) begin
      if (cmd.clear) mark_mem[cmd.clear_addr] <= qpht_pkg::MARK_EMPTY;
      else if (cmd.finish && cmd.stopped) begin
         if (op_ff == qpht_pkg::OP_INSERT) mark_mem[pos_ff] <= qpht_pkg::MARK_VALID;
         else if (op_ff == qpht_pkg::OP_REMOVE && mark_rd_ff == qpht_pkg::MARK_VALID)
            mark_mem[pos_ff] <= qpht_pkg::MARK_DELETED;
      end
      mark_rd_ff <= mark_mem[pos_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.finish && cmd.stopped && op_ff == qpht_pkg::OP_INSERT) begin
         key_mem[pos_ff] <= key_ff;
         val_mem[pos_ff] <= val_ff;
      end
      key_rd_ff <= key_mem[pos_ff];
      val_rd_ff <= val_mem[pos_ff];
   end

   always_comb begin
      if (op_ff == qpht_pkg::OP_INSERT) sts.pass = (mark_rd_ff == qpht_pkg::MARK_VALID);
      else sts.pass = (mark_rd_ff == qpht_pkg::MARK_DELETED) ||
                      (mark_rd_ff == qpht_pkg::MARK_VALID && key_rd_ff != key_ff);
      sts.k_last   = (k_ff == t_ff - 1'b1);
      sts.rsp_busy = rsp_valid_ff && !rsp_ready;
   end

   // response register
   always_comb begin
      hit     = cmd.stopped && (mark_rd_ff == qpht_pkg::MARK_VALID);
      vout_in = '0;
      if (op_ff == qpht_pkg::OP_INSERT) begin
         status_in = cmd.stopped ? qpht_pkg::STAT_DONE : qpht_pkg::STAT_FULL;
      end else begin
         status_in = hit ? qpht_pkg::STAT_DONE : qpht_pkg::STAT_MISS;
         if (hit && op_ff != qpht_pkg::OP_REMOVE) vout_in = val_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.finish) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         status_ff <= status_in;
         vout_ff   <= vout_in;
         slot_ff   <= pos_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = status_ff;
   assign rsp_value_out = vout_ff;
   assign rsp_slot      = slot_ff;

endmodule
`default_nettype wire

// ===== tb/tb_quadratic_probe_hash_table.sv =====
// ----------------------------------------------------------------------------
// tb_quadratic_probe_hash_table: self-checking bench for the hash table
// A queue-fed driver sends find, insert and remove operations over the
// request channel and a table model in the bench predicts each response.
// The monitor compares every response transfer field by field. Table sizes
// are changed between phases while the block is idle, and both channels
// stall at random.
// ----------------------------------------------------------------------------
module tb_quadratic_probe_hash_table;

   typedef struct packed {
      qpht_pkg::op_type                 op;
      logic [qpht_pkg::IP_WIDTH-1:0]    ip_addr;
      logic [qpht_pkg::SEQ_WIDTH-1:0]   seq;
      logic [qpht_pkg::VALUE_WIDTH-1:0] value_in;
   } op_item_type;

   typedef struct packed {
      qpht_pkg::status_type             status;
      logic [qpht_pkg::VALUE_WIDTH-1:0] value_out;
      logic [qpht_pkg::IDX_W-1:0]       slot;
   } answer_type;

   localparam int STALL_LIMIT = 40000;
   // unused op code, behaves as find
   localparam qpht_pkg::op_type OP_UNUSED = 2'd3;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       csr_we = 1'b0;
   logic [qpht_pkg::CSR_W-1:0] csr_wdata = '0;
   logic                       quiet = 1'b0;
   int                         errors = 0;
   int                         stall_cycles = 0;

   op_item_type pending_ops[$];
   answer_type  answers_due[$];

   // table image
   logic [qpht_pkg::KEY_W-1:0]       img_key[qpht_pkg::TABLE_DEPTH];
   logic [qpht_pkg::VALUE_WIDTH-1:0] img_value[qpht_pkg::TABLE_DEPTH];
   qpht_pkg::mark_type               img_mark[qpht_pkg::TABLE_DEPTH];
   int unsigned                      size_reg = qpht_pkg::CSR_RESET;

   qpht_req_if req_if ();
   qpht_rsp_if rsp_if ();

   quadratic_probe_hash_table u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   initial begin
      req_if.valid    = 1'b0;
      req_if.op       = qpht_pkg::OP_FIND;
      req_if.ip_addr  = '0;
      req_if.seq      = '0;
      req_if.value_in = '0;
      rsp_if.ready    = 1'b0;
      foreach (img_mark[i]) img_mark[i] = qpht_pkg::MARK_EMPTY;
   end

   function automatic answer_type apply_op(op_item_type r);
      answer_type                 a;
      int unsigned                t, h, pos, k, q, sq;
      bit                         stop;
      bit                         pass;
      logic [qpht_pkg::KEY_W-1:0] key;
      key = {r.ip_addr, r.seq};
      t = size_reg;
      if (t < 2) t = 2;
      if (t > qpht_pkg::TABLE_DEPTH) t = qpht_pkg::TABLE_DEPTH;
      h = r.seq % t;
      for (int i = 3; i >= 0; i--) h = (31 * h + r.ip_addr[8*i +: 8]) % t;
      pos = h;
      stop = 1'b0;
      k = 0;
      while (k < t) begin
         if (k > 0) begin
            q = (k + 1) / 2;
            sq = (q * q) % t;
            if (k & 1) pos = (h + sq) % t;
            else pos = (h + t - sq) % t;
         end
         if (r.op == qpht_pkg::OP_INSERT) pass = (img_mark[pos] == qpht_pkg::MARK_VALID);
         else pass = (img_mark[pos] == qpht_pkg::MARK_DELETED) ||
                     (img_mark[pos] == qpht_pkg::MARK_VALID && img_key[pos] != key);
         if (!pass) begin
            stop = 1'b1;
            break;
         end
         k++;
      end
      a.status = qpht_pkg::STAT_DONE;
      a.value_out = '0;
      a.slot = pos[qpht_pkg::IDX_W-1:0];
      if (r.op == qpht_pkg::OP_INSERT) begin
         if (stop) begin
            img_key[pos] = key;
            img_value[pos] = r.value_in;
            img_mark[pos] = qpht_pkg::MARK_VALID;
         end else begin
            a.status = qpht_pkg::STAT_FULL;
         end
      end else if (stop && img_mark[pos] == qpht_pkg::MARK_VALID) begin
         if (r.op == qpht_pkg::OP_REMOVE) img_mark[pos] = qpht_pkg::MARK_DELETED;
         else a.value_out = img_value[pos];
      end else begin
         a.status = qpht_pkg::STAT_MISS;
      end
      return a;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (req_if.valid)
            answers_due.push_back(apply_op({req_if.op, req_if.ip_addr, req_if.seq,
                                            req_if.value_in}));
         if (pending_ops.size() > 0 && (quiet || $urandom_range(99) >= 38)) begin
            op_item_type nx;
            nx = pending_ops.pop_front();
            req_if.valid    <= 1'b1;
            req_if.op       <= nx.op;
            req_if.ip_addr  <= nx.ip_addr;
            req_if.seq      <= nx.seq;
            req_if.value_in <= nx.value_in;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (answers_due.size() == 0) begin
               $error("response transfer with nothing expected");
               errors++;
            end else begin
               answer_type ex;
               ex = answers_due.pop_front();
               if (rsp_if.status !== ex.status) begin
                  $error("status: expected %0d actual %0d", ex.status, rsp_if.status);
                  errors++;
               end
               if (rsp_if.value_out !== ex.value_out) begin
                  $error("value_out: expected %0h actual %0h", ex.value_out,
                         rsp_if.value_out);
                  errors++;
               end
               if (rsp_if.slot !== ex.slot) begin
                  $error("slot: expected %0d actual %0d", ex.slot, rsp_if.slot);
                  errors++;
               end
            end
         end
         rsp_if.ready <= quiet || ($urandom_range(99) >= 38);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic push_op(qpht_pkg::op_type op, logic [31:0] ip, logic [15:0] seq,
                          logic [31:0] val);
      op_item_type it;
      it.op = op;
      it.ip_addr = ip;
      it.seq = seq;
      it.value_in = val;
      pending_ops.push_back(it);
   endtask

   task automatic drain(int unsigned settle);
      @(negedge clock);
      while (pending_ops.size() > 0 || req_if.valid || answers_due.size() > 0)
         @(negedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_size(logic [qpht_pkg::CSR_W-1:0] v);
      drain(2 * qpht_pkg::TABLE_DEPTH + 200);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      size_reg = v;
   endtask

   task automatic random_phase(int n);
      logic [31:0]      pool_ip[20];
      logic [15:0]      pool_seq[20];
      int               pool_n;
      int               sel, r;
      qpht_pkg::op_type op;
      logic [31:0]      ip;
      logic [15:0]      seq;
      pool_n = $urandom_range(20, 3);
      for (int i = 0; i < pool_n; i++) begin
         pool_ip[i] = $urandom();
         pool_seq[i] = 16'($urandom());
      end
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(99);
         if (r < 40) op = qpht_pkg::OP_INSERT;
         else if (r < 75) op = qpht_pkg::OP_FIND;
         else if (r < 95) op = qpht_pkg::OP_REMOVE;
         else op = OP_UNUSED;
         if ($urandom_range(99) < 75) begin
            sel = $urandom_range(pool_n - 1);
            ip = pool_ip[sel];
            seq = pool_seq[sel];
         end else begin
            ip = $urandom();
            seq = 16'($urandom());
         end
         push_op(op, ip, seq, $urandom());
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes and every op at reset size
      push_op(qpht_pkg::OP_FIND,   32'h0000_0000, 16'h0000, 32'h0);
      push_op(qpht_pkg::OP_INSERT, 32'h0000_0000, 16'h0000, 32'hffff_ffff);
      push_op(qpht_pkg::OP_INSERT, 32'hffff_ffff, 16'hffff, 32'h0000_0000);
      push_op(qpht_pkg::OP_INSERT, 32'hffff_ffff, 16'hffff, 32'ha5a5_5a5a);
      push_op(qpht_pkg::OP_FIND,   32'h0000_0000, 16'h0000, 32'h1234_5678);
      push_op(qpht_pkg::OP_FIND,   32'hffff_ffff, 16'hffff, 32'h0);
      push_op(OP_UNUSED,           32'hffff_ffff, 16'hffff, 32'hffff_ffff);
      push_op(qpht_pkg::OP_REMOVE, 32'hffff_ffff, 16'hffff, 32'hffff_ffff);
      push_op(qpht_pkg::OP_FIND,   32'hffff_ffff, 16'hffff, 32'h0);
      push_op(qpht_pkg::OP_REMOVE, 32'hffff_ffff, 16'hffff, 32'h0);
      push_op(qpht_pkg::OP_FIND,   32'h8000_0001, 16'h8001, 32'h0);
      drain(0);

      // tiny table: fills up, probe limit on insert and find
      write_size(11'd2);
      push_op(qpht_pkg::OP_INSERT, 32'h0102_0304, 16'h0001, 32'h1111_1111);
      push_op(qpht_pkg::OP_INSERT, 32'h0506_0708, 16'h0002, 32'h2222_2222);
      push_op(qpht_pkg::OP_INSERT, 32'h090a_0b0c, 16'h0003, 32'h3333_3333);
      push_op(qpht_pkg::OP_FIND,   32'hdead_beef, 16'h0004, 32'h0);
      push_op(qpht_pkg::OP_REMOVE, 32'h0102_0304, 16'h0001, 32'h0);
      push_op(qpht_pkg::OP_FIND,   32'h0506_0708, 16'h0002, 32'h0);
      push_op(qpht_pkg::OP_REMOVE, 32'hdead_beef, 16'h0004, 32'h0);
      push_op(qpht_pkg::OP_INSERT, 32'hdead_beef, 16'h0004, 32'h4444_4444);
      push_op(qpht_pkg::OP_FIND,   32'hdead_beef, 16'h0004, 32'h0);
      drain(0);

      // out of range sizes
      write_size(11'd0);
      random_phase(60);
      write_size(11'd1);
      random_phase(60);
      write_size(11'h7ff);
      random_phase(20);

      // sender holds off until all results are back
      write_size(11'd5);
      random_phase(60);
      drain(0);
      random_phase(60);

      quiet = 1'b1;
      write_size(11'd7);
      random_phase(150);
      drain(0);
      quiet = 1'b0;

      write_size(11'd3);
      random_phase(150);
      write_size(11'd13);
      random_phase(150);
      write_size(11'd31);
      random_phase(150);
      write_size(11'd11);
      random_phase(150);
      write_size(11'd97);
      random_phase(150);
      write_size(11'd1024);
      random_phase(25);
      write_size(11'd1021);
      random_phase(25);
      write_size(11'd17);
      random_phase(220);

      drain(2 * qpht_pkg::TABLE_DEPTH + 200);
      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
